// ===== rtl/octenc_pkg.sv =====
// Shared widths and the pipeline control word for the octahedral normal encoder.
package octenc_pkg;

  localparam int COMP_W = 16;  // signed component
  localparam int MAG_W  = 16;  // magnitude, holds 32768
  localparam int SUM_W  = 17;  // L1 norm, up to 98304
  localparam int OFF_W  = 18;  // num + s, up to 2s
  localparam int DEN_W  = 18;  // divisor 2s
  localparam int CODE_W = 16;  // packed output code

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

// ===== rtl/octenc_prep.sv =====
// Front end: magnitudes, L1 norm, fold offsets, then dividend and divisor for the cell row.
module octenc_prep #(
  parameter int AXIS_BITS = 8
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       accept_i,
  input  logic signed [octenc_pkg::COMP_W-1:0]       comp_x_i,
  input  logic signed [octenc_pkg::COMP_W-1:0]       comp_y_i,
  input  logic signed [octenc_pkg::COMP_W-1:0]       comp_z_i,
  output octenc_pkg::ctl_t                           ctl_o,
  output logic [AXIS_BITS+octenc_pkg::DEN_W-1:0]     num_x_o,
  output logic [AXIS_BITS+octenc_pkg::DEN_W-1:0]     num_y_o,
  output logic [octenc_pkg::DEN_W-1:0]               den_o
);
  import octenc_pkg::*;

  localparam int NUM_W = AXIS_BITS + DEN_W;

  // stage 1: magnitudes and signs
  logic             s1_valid_q;
  logic [MAG_W-1:0] ax_d, ay_d, az_d;
  logic [MAG_W-1:0] ax_q, ay_q, az_q;
  logic             xneg_q, yneg_q, fold_q;

  assign ax_d = comp_x_i[COMP_W-1] ? (~comp_x_i + 16'd1) : comp_x_i;
  assign ay_d = comp_y_i[COMP_W-1] ? (~comp_y_i + 16'd1) : comp_y_i;
  assign az_d = comp_z_i[COMP_W-1] ? (~comp_z_i + 16'd1) : comp_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    az_q   <= az_d;
    xneg_q <= comp_x_i[COMP_W-1];
    yneg_q <= comp_y_i[COMP_W-1];
    fold_q <= comp_z_i[COMP_W-1];
  end

  // stage 2: s and the offsets num + s
  // fold:    x >= 0 -> 2s - |y| = 2|x| + |y| + 2|z|,  x < 0 -> |y|
  // no fold: x >= 0 -> 2|x| + |y| + |z|,              x < 0 -> |y| + |z|
  ctl_t             s2_ctl_d, s2_ctl_q;
  logic [SUM_W-1:0] s_d, s_q;
  logic [OFF_W-1:0] offx_d, offy_d, offx_q, offy_q;
  logic [OFF_W-1:0] ex, ey, ez;

  assign ex  = OFF_W'(ax_q);
  assign ey  = OFF_W'(ay_q);
  assign ez  = OFF_W'(az_q);
  assign s_d = SUM_W'(ax_q) + SUM_W'(ay_q) + SUM_W'(az_q);

  always_comb begin
    if (fold_q) begin
      offx_d = xneg_q ? ey : (ex << 1) + ey + (ez << 1);
      offy_d = yneg_q ? ex : (ey << 1) + ex + (ez << 1);
    end else begin
      offx_d = xneg_q ? ey + ez : (ex << 1) + ey + ez;
      offy_d = yneg_q ? ex + ez : (ey << 1) + ex + ez;
    end
    s2_ctl_d.valid = s1_valid_q;
    s2_ctl_d.zero  = (s_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else begin
      s2_ctl_q <= s2_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    offx_q <= offx_d;
    offy_q <= offy_d;
  end

  // stage 3: dividend M*off + s as (off << A) - off + s, divisor 2s
  logic [NUM_W-1:0] numx_d, numy_d;

  assign numx_d = (NUM_W'(offx_q) << AXIS_BITS) - NUM_W'(offx_q) + NUM_W'(s_q);
  assign numy_d = (NUM_W'(offy_q) << AXIS_BITS) - NUM_W'(offy_q) + NUM_W'(s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= s2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_x_o <= numx_d;
    num_y_o <= numy_d;
    den_o   <= {s_q, 1'b0};
  end

endmodule

// ===== rtl/octenc_div_cell.sv =====
// One restoring-division cell: settles one quotient bit of both axes and passes on.
module octenc_div_cell #(
  parameter int AXIS_BITS = 8,
  parameter int SHIFT     = 0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  octenc_pkg::ctl_t                           ctl_i,
  input  logic [AXIS_BITS+octenc_pkg::DEN_W-1:0]     rem_x_i,
  input  logic [AXIS_BITS+octenc_pkg::DEN_W-1:0]     rem_y_i,
  input  logic [octenc_pkg::DEN_W-1:0]               den_i,
  input  logic [AXIS_BITS-1:0]                       qx_i,
  input  logic [AXIS_BITS-1:0]                       qy_i,
  output octenc_pkg::ctl_t                           ctl_o,
  output logic [AXIS_BITS+octenc_pkg::DEN_W-1:0]     rem_x_o,
  output logic [AXIS_BITS+octenc_pkg::DEN_W-1:0]     rem_y_o,
  output logic [octenc_pkg::DEN_W-1:0]               den_o,
  output logic [AXIS_BITS-1:0]                       qx_o,
  output logic [AXIS_BITS-1:0]                       qy_o
);
  import octenc_pkg::*;

  localparam int NUM_W = AXIS_BITS + DEN_W;

  logic [NUM_W-1:0] dsh;
  logic             bx, by;
  logic [NUM_W-1:0] rem_x_d, rem_y_d;

  assign dsh     = NUM_W'(den_i) << SHIFT;
  assign bx      = (rem_x_i >= dsh);
  assign by      = (rem_y_i >= dsh);
  assign rem_x_d = bx ? rem_x_i - dsh : rem_x_i;
  assign rem_y_d = by ? rem_y_i - dsh : rem_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_x_o <= rem_x_d;
    rem_y_o <= rem_y_d;
    den_o   <= den_i;
    qx_o    <= {qx_i[AXIS_BITS-2:0], bx};
    qy_o    <= {qy_i[AXIS_BITS-2:0], by};
  end

endmodule

// ===== rtl/octahedral_normal_encode_top.sv =====
// Pipeline from the accepting edge to the edge that takes the result: three front-end stages,
// one division cell per quotient bit (each cell settles that bit for both axes), output register.
// Throughput: one transaction per cycle; busy_o is always low, the cell row is fully pipelined.
// The receiver cannot stall; valid_o marks each result for exactly one cycle.
// Reset (rst_ni, async low) clears all valid flags; no result appears until new transactions.
module octahedral_normal_encode_top #(
  parameter int AXIS_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [octenc_pkg::COMP_W-1:0] comp_x_i,
  input  logic signed [octenc_pkg::COMP_W-1:0] comp_y_i,
  input  logic signed [octenc_pkg::COMP_W-1:0] comp_z_i,
  output logic                                 valid_o,
  output logic [octenc_pkg::CODE_W-1:0]        oct_code_o
);
  import octenc_pkg::*;

  localparam int NUM_W   = AXIS_BITS + DEN_W;
  localparam int LATENCY = AXIS_BITS + 4;

  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  ctl_t             ctl_c  [AXIS_BITS+1];
  logic [NUM_W-1:0] rem_x  [AXIS_BITS+1];
  logic [NUM_W-1:0] rem_y  [AXIS_BITS+1];
  logic [DEN_W-1:0] den_c  [AXIS_BITS+1];
  logic [AXIS_BITS-1:0] qx_c [AXIS_BITS+1];
  logic [AXIS_BITS-1:0] qy_c [AXIS_BITS+1];

  octenc_prep #(
    .AXIS_BITS(AXIS_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .comp_x_i(comp_x_i),
    .comp_y_i(comp_y_i),
    .comp_z_i(comp_z_i),
    .ctl_o   (ctl_c[0]),
    .num_x_o (rem_x[0]),
    .num_y_o (rem_y[0]),
    .den_o   (den_c[0])
  );

  assign qx_c[0] = '0;
  assign qy_c[0] = '0;

  // cell i resolves quotient bit AXIS_BITS-1-i, msb first
  for (genvar i = 0; i < AXIS_BITS; i++) begin : g_cell
    octenc_div_cell #(
      .AXIS_BITS(AXIS_BITS),
      .SHIFT    (AXIS_BITS - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[i]),
      .rem_x_i(rem_x[i]),
      .rem_y_i(rem_y[i]),
      .den_i  (den_c[i]),
      .qx_i   (qx_c[i]),
      .qy_i   (qy_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .rem_x_o(rem_x[i+1]),
      .rem_y_o(rem_y[i+1]),
      .den_o  (den_c[i+1]),
      .qx_o   (qx_c[i+1]),
      .qy_o   (qy_c[i+1])
    );
  end

  // output register; zero vector forces code 0
  logic [2*AXIS_BITS-1:0] packed_code;
  logic [CODE_W-1:0]      code_d, code_q;
  logic                   valid_q;

  assign packed_code = {qx_c[AXIS_BITS], qy_c[AXIS_BITS]};
  assign code_d      = ctl_c[AXIS_BITS].zero ? '0 : CODE_W'(packed_code);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_c[AXIS_BITS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign valid_o    = valid_q;
  assign oct_code_o = code_q;

  // every result comes from a matching earlier transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without matching transaction");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY valid_o)
    else $error("transaction lost in pipeline");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(comp_x_i == '0 && comp_y_i == '0 && comp_z_i == '0, LATENCY))
      |-> (oct_code_o == '0))
    else $error("zero vector did not give code 0");

endmodule
